[hw/rtl/lpsc_pkg.sv]
// ----------------------------------------------------------------------------
// Lift position slowdown controller package
// Shared types, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package lpsc_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_PULSE = 2'd2
  } action_t;

  localparam logic CFG_COUNTS_PER_UNIT = 1'b0;
  localparam logic CFG_SENSOR_COUNT    = 1'b1;

  localparam logic [1:0] BUSY_IDLE      = 2'd0;
  localparam logic [1:0] BUSY_VERY_NEAR = 2'd1;
  localparam logic [1:0] BUSY_NEAR      = 2'd2;
  localparam logic [1:0] BUSY_FULL      = 2'd3;

  localparam logic [14:0] COUNTS_PER_UNIT_RST = 15'd7700;

  localparam int SPEED_MIN        = 2;
  localparam int SPEED_MAX        = 100;
  localparam int NEAR_COUNTS      = 154;
  localparam int VERY_NEAR_COUNTS = 77;
  localparam int VERY_NEAR_DUTY   = 25;
  localparam int NEAR_DUTY_LIMIT  = 128;
  localparam int NEAR_DUTY        = 50;

  // Division by 10000 is a shift by four followed by a reciprocal multiply
  // for 625, exact for dividends below 2**27.
  localparam int          RECIP_625_SHIFT = 37;
  localparam logic [27:0] RECIP_625       = 28'd219902326;

  // Duty is speed * 255 / 100 = ((speed * 51) >> 2) / 5.
  localparam logic [12:0] DUTY_MUL       = 13'd51;
  localparam int          RECIP_5_SHIFT  = 13;
  localparam logic [10:0] RECIP_5        = 11'd1639;

endpackage

[hw/rtl/lpsc_scale.sv]
// ----------------------------------------------------------------------------
// Lift position slowdown controller end count scaler
// Turns the registered magnitude of target times scale into the signed end
// count, dividing by 10000 with truncation toward zero.
// ----------------------------------------------------------------------------
module lpsc_scale
  import lpsc_pkg::*;
(
  input  logic [30:0]        prod_mag,
  input  logic               prod_neg,
  output logic signed [17:0] end_count
);

  logic [26:0] quot_in;
  logic [54:0] recip_prod;
  logic [17:0] quot;

  assign quot_in    = prod_mag[30:4];
  assign recip_prod = 55'(quot_in) * 55'(RECIP_625);
  assign quot       = recip_prod[RECIP_625_SHIFT +: 18];
  assign end_count  = prod_neg ? $signed(~quot + 18'd1) : $signed(quot);

endmodule

[hw/rtl/lift_position_slowdown_controller.sv]
// ----------------------------------------------------------------------------
// Lift position slowdown controller
// Start, stop and tacho pulse requests drive a lift motor toward an end count.
//
// Requests enter on the in_ channel and every request yields exactly one
// result on the out_ channel, carrying the motor drive state after it.
// A request is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// A request passes the input register, then the result register. One request
// is accepted in every cycle unless the receiver stalls; the rate is set
// by the single execute stage between them, which holds all controller state.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall then rises until the result is taken.
// The cfg_ channel writes counts_per_unit (index 0) and sensor_count
// (index 1); cfg_ready is always high. Writes must be made only while idle;
// the block does not enforce it. Reset clears the motor state, the position,
// and the channels, and loads a scale of 7700 and a sensor count of zero.
// ----------------------------------------------------------------------------
module lift_position_slowdown_controller
  import lpsc_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_speed_percent,
  input  logic signed [15:0] in_target_position,
  input  logic               in_sensor_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_pwm_output,
  output logic               out_direction_up,
  output logic               out_clock_enable,
  output logic               out_high_current,
  output logic [1:0]         out_busy_level,
  output logic signed [15:0] out_position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CW = ((POSITION_BITS > 18) ? POSITION_BITS : 18) + 1;

  logic               in_accept;
  logic               advance;

  logic [14:0]        cpu_r;
  logic signed [15:0] sc_r;

  logic               in_vld_r, in_vld_nxt;
  action_t            act_r;
  logic [7:0]         spd_r;
  logic               sens_r;
  logic [30:0]        prod_r;
  logic               neg_r;

  logic [15:0]        tgt_u;
  logic [15:0]        tgt_mag;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic signed [17:0] end_r, end_nxt;
  logic [7:0]         duty_r, duty_nxt;
  logic [7:0]         drv_r, drv_nxt;
  logic               last_r, last_nxt;
  logic               up_r, up_nxt;
  logic               run_r, run_nxt;
  logic               strong_r, strong_nxt;
  logic [1:0]         busy_r, busy_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [7:0]         o_pwm_r;
  logic               o_up_r, o_run_r, o_strong_r;
  logic [1:0]         o_busy_r;
  logic [15:0]        o_pos_r;

  logic signed [17:0] end_calc;
  logic [6:0]         spd_clamp;
  logic [12:0]        spd_x51;
  logic [23:0]        duty_prod;
  logic [7:0]         start_duty;
  logic signed [CW-1:0] pos_ext, end_ext, step_ext, rem;
  logic signed [CW-1:0] new_end_ext;
  logic [POSITION_BITS-1:0] sens_pos, pos_base, pos_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_r <= COUNTS_PER_UNIT_RST;
      sc_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COUNTS_PER_UNIT: cpu_r <= cfg_data[14:0];
        CFG_SENSOR_COUNT:    sc_r  <= $signed(cfg_data);
        default:             cpu_r <= cpu_r;
      endcase
    end
  end

  // Input register with the target magnitude already multiplied by the scale.
  assign advance    = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall   = in_vld_r && !advance;
  assign in_accept  = in_valid && !in_stall;
  assign in_vld_nxt = in_accept || (in_vld_r && !advance);

  assign tgt_u   = $unsigned(in_target_position);
  assign tgt_mag = tgt_u[15] ? (~tgt_u + 16'd1) : tgt_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r  <= action_t'(in_action);
      spd_r  <= in_speed_percent;
      sens_r <= in_sensor_level;
      prod_r <= 31'(tgt_mag) * 31'(cpu_r);
      neg_r  <= tgt_u[15];
    end
  end

  lpsc_scale u_scale (
    .prod_mag  (prod_r),
    .prod_neg  (neg_r),
    .end_count (end_calc)
  );

  assign spd_clamp  = (spd_r < 8'(SPEED_MIN)) ? 7'(SPEED_MIN) :
                      (spd_r > 8'(SPEED_MAX)) ? 7'(SPEED_MAX) : spd_r[6:0];
  assign spd_x51    = 13'(spd_clamp) * DUTY_MUL;
  assign duty_prod  = 24'(spd_x51[12:2]) * 24'(RECIP_5);
  assign start_duty = duty_prod[RECIP_5_SHIFT +: 8];

  assign pos_ext     = CW'($signed(pos_r));
  assign end_ext     = CW'(end_r);
  assign new_end_ext = CW'(end_calc);
  assign sens_pos    = POSITION_BITS'(CW'(sc_r));
  assign pos_base    = (sens_r != last_r) ? sens_pos : pos_r;
  assign pos_step    = up_r ? (pos_base + 1'b1) : (pos_base - 1'b1);
  assign step_ext    = CW'($signed(pos_step));
  assign rem         = up_r ? (end_ext - step_ext) : (step_ext - end_ext);

  always_comb begin
    pos_nxt    = pos_r;
    end_nxt    = end_r;
    duty_nxt   = duty_r;
    drv_nxt    = drv_r;
    last_nxt   = last_r;
    up_nxt     = up_r;
    run_nxt    = run_r;
    strong_nxt = strong_r;
    busy_nxt   = busy_r;
    if (advance) begin
      case (act_r)
        ACT_START: begin
          if (spd_r != 8'd0) begin
            end_nxt  = end_calc;
            last_nxt = sens_r;
            duty_nxt = start_duty;
            if (pos_ext != new_end_ext) begin
              up_nxt     = pos_ext < new_end_ext;
              strong_nxt = 1'b1;
              drv_nxt    = start_duty;
              busy_nxt   = BUSY_FULL;
              run_nxt    = 1'b1;
            end
          end
        end
        ACT_STOP: begin
          drv_nxt    = 8'd0;
          busy_nxt   = BUSY_IDLE;
          run_nxt    = 1'b0;
          strong_nxt = 1'b0;
        end
        ACT_PULSE: begin
          if (run_r) begin
            last_nxt = sens_r;
            pos_nxt  = pos_step;
            if (rem <= NEAR_COUNTS) begin
              if (rem <= VERY_NEAR_COUNTS) begin
                busy_nxt = BUSY_VERY_NEAR;
                if (duty_r > 8'(VERY_NEAR_DUTY)) begin
                  duty_nxt = 8'(VERY_NEAR_DUTY);
                end
              end else begin
                busy_nxt = BUSY_NEAR;
                if (duty_r > 8'(NEAR_DUTY_LIMIT)) begin
                  duty_nxt = 8'(NEAR_DUTY);
                end
              end
              drv_nxt = duty_nxt;
            end
            if (rem <= 0) begin
              busy_nxt   = BUSY_IDLE;
              run_nxt    = 1'b0;
              strong_nxt = 1'b0;
              duty_nxt   = 8'd1;
              drv_nxt    = 8'd1;
            end
          end
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      end_r    <= '0;
      duty_r   <= '0;
      drv_r    <= '0;
      last_r   <= 1'b0;
      up_r     <= 1'b1;
      run_r    <= 1'b0;
      strong_r <= 1'b0;
      busy_r   <= BUSY_IDLE;
    end else begin
      pos_r    <= pos_nxt;
      end_r    <= end_nxt;
      duty_r   <= duty_nxt;
      drv_r    <= drv_nxt;
      last_r   <= last_nxt;
      up_r     <= up_nxt;
      run_r    <= run_nxt;
      strong_r <= strong_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // Result register.
  assign out_vld_nxt = advance || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_pwm_r    <= drv_nxt;
      o_up_r     <= up_nxt;
      o_run_r    <= run_nxt;
      o_strong_r <= strong_nxt;
      o_busy_r   <= busy_nxt;
      o_pos_r    <= 16'(pos_nxt);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pwm_output   = o_pwm_r;
  assign out_direction_up = o_up_r;
  assign out_clock_enable = o_run_r;
  assign out_high_current = o_strong_r;
  assign out_busy_level   = o_busy_r;
  assign out_position     = $signed(o_pos_r);

  // The motor runs exactly when a busy level is shown.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_r == (busy_r != BUSY_IDLE))
    else $error("running and busy level disagree");

  // High current is applied only during a move.
  a_run_strong: assert property (@(posedge clk) disable iff (!rst_n)
    run_r == strong_r)
    else $error("drive current and running disagree");

  // A stop request leaves the motor stopped.
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && act_r == ACT_STOP) |=> (!run_r && drv_r == 8'd0))
    else $error("stop request did not stop the motor");

  // A tacho pulse while idle does not move the position.
  a_idle_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && act_r == ACT_PULSE && !run_r) |=> $stable(pos_r))
    else $error("position changed on an idle pulse");

endmodule

[sim/lift_drive_checker.sv]
// ----------------------------------------------------------------------------
// Lift drive result checker
// Watches the request, result and register channels of the lift position
// slowdown controller. It keeps its own copy of the motor drive state and
// register settings, works out the drive state that each accepted request
// must leave behind, and compares every accepted result with the oldest one
// still waiting. The number of failures is handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lift_drive_checker
  import lpsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_speed_percent,
  input  logic signed [15:0] in_target_position,
  input  logic               in_sensor_level,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_pwm_output,
  input  logic               out_direction_up,
  input  logic               out_clock_enable,
  input  logic               out_high_current,
  input  logic [1:0]         out_busy_level,
  input  logic signed [15:0] out_position,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_checked,
  output int                 arrivals
);

  localparam int SCALE_DIVISOR = 10000;

  typedef struct packed {
    logic [7:0]         pwm;
    logic               dir_up;
    logic               clk_en;
    logic               hi_cur;
    logic [1:0]         busy;
    logic signed [15:0] pos;
  } drive_state_t;

  logic [14:0]        scale;
  logic signed [15:0] home_cnt;

  logic signed [15:0] pos_cnt;
  logic signed [17:0] end_cnt;
  logic [7:0]         duty_lvl;
  logic [7:0]         drv_duty;
  logic               last_sens;
  logic               moving_up;
  logic               running;
  logic               hi_drive;
  logic [1:0]         busy;

  drive_state_t expected_drive_q[$];
  int           err_cnt;
  int           seen_cnt;
  int           arrive_cnt;

  task automatic update_drive_state(input logic [1:0] act, input logic [7:0] spd,
                                    input logic signed [15:0] tgt, input logic lvl);
    int sp;
    int goal;
    int here;
    int left;
    case (act)
      ACT_START: if (spd != 8'd0) begin
        goal = (int'(tgt) * int'(scale)) / SCALE_DIVISOR;
        end_cnt = 18'(goal);
        last_sens = lvl;
        sp = int'(spd);
        if (sp < SPEED_MIN) sp = SPEED_MIN;
        if (sp > SPEED_MAX) sp = SPEED_MAX;
        duty_lvl = 8'(sp * 255 / 100);
        here = int'(pos_cnt);
        if (here != int'(end_cnt)) begin
          moving_up = (here < int'(end_cnt));
          hi_drive = 1'b1;
          drv_duty = duty_lvl;
          busy = BUSY_FULL;
          running = 1'b1;
        end
      end
      ACT_STOP: begin
        drv_duty = 8'd0;
        busy = BUSY_IDLE;
        running = 1'b0;
        hi_drive = 1'b0;
      end
      ACT_PULSE: if (running) begin
        if (lvl != last_sens) pos_cnt = home_cnt;
        last_sens = lvl;
        if (moving_up) begin
          pos_cnt = pos_cnt + 16'sd1;
          left = int'(end_cnt) - int'(pos_cnt);
        end else begin
          pos_cnt = pos_cnt - 16'sd1;
          left = int'(pos_cnt) - int'(end_cnt);
        end
        if (left <= NEAR_COUNTS) begin
          if (left <= VERY_NEAR_COUNTS) begin
            busy = BUSY_VERY_NEAR;
            if (duty_lvl > VERY_NEAR_DUTY) duty_lvl = 8'(VERY_NEAR_DUTY);
          end else begin
            busy = BUSY_NEAR;
            if (duty_lvl > NEAR_DUTY_LIMIT) duty_lvl = 8'(NEAR_DUTY);
          end
          drv_duty = duty_lvl;
        end
        if (left <= 0) begin
          busy = BUSY_IDLE;
          running = 1'b0;
          hi_drive = 1'b0;
          duty_lvl = 8'd1;
          drv_duty = 8'd1;
          arrive_cnt++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    drive_state_t got;
    drive_state_t want;
    if (!rst_n) begin
      scale = COUNTS_PER_UNIT_RST;
      home_cnt = '0;
      pos_cnt = '0;
      end_cnt = '0;
      duty_lvl = '0;
      drv_duty = '0;
      last_sens = 1'b0;
      moving_up = 1'b1;
      running = 1'b0;
      hi_drive = 1'b0;
      busy = BUSY_IDLE;
      expected_drive_q.delete();
      err_cnt = 0;
      seen_cnt = 0;
      arrive_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COUNTS_PER_UNIT: scale = cfg_data[14:0];
          CFG_SENSOR_COUNT:    home_cnt = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_pwm_output, out_direction_up, out_clock_enable, out_high_current,
                out_busy_level, out_position};
        seen_cnt++;
        if (expected_drive_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no request waiting: pwm=%0d pos=%0d",
                   $time, got.pwm, got.pos);
        end else begin
          want = expected_drive_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display({"%0t: result mismatch, expected pwm=%0d up=%0d en=%0d hi=%0d ",
                      "busy=%0d pos=%0d, actual pwm=%0d up=%0d en=%0d hi=%0d ",
                      "busy=%0d pos=%0d"},
                     $time, want.pwm, want.dir_up, want.clk_en, want.hi_cur,
                     want.busy, want.pos, got.pwm, got.dir_up, got.clk_en,
                     got.hi_cur, got.busy, got.pos);
          end
        end
      end
      if (in_valid && !in_stall) begin
        update_drive_state(in_action, in_speed_percent, in_target_position,
                           in_sensor_level);
        expected_drive_q.push_back('{drv_duty, moving_up, running, hi_drive, busy,
                                     pos_cnt});
      end
    end
    mismatches <= err_cnt;
    outstanding <= expected_drive_q.size();
    results_checked <= seen_cnt;
    arrivals <= arrive_cnt;
  end

endmodule

[sim/lift_position_slowdown_controller_tb.sv]
// ----------------------------------------------------------------------------
// Lift position slowdown controller testbench
// Drives start, stop and tacho pulse requests into the controller with random
// gaps and result stalls, across several scale and sensor count settings.
// A short directed part covers ignored starts, starts at the end count,
// stops, idle pulses and the unused action code; the random part is built
// from complete moves: start, sensor reload, start toward a nearby end count
// and a run of pulses through the slowdown zones to the end. The checker
// beside the controller predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lift_position_slowdown_controller_tb;
  import lpsc_pkg::*;

  localparam logic [1:0] ACT_UNUSED      = 2'd3;
  localparam int         ITEM_TARGET     = 1800;
  localparam int         PHASE_ITEMS     = 260;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         DRAIN_CYCLES    = 4;
  localparam int         WATCHDOG_LIMIT  = 5000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic [7:0]         in_speed_percent;
  logic signed [15:0] in_target_position;
  logic               in_sensor_level;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_pwm_output;
  logic               out_direction_up;
  logic               out_clock_enable;
  logic               out_high_current;
  logic [1:0]         out_busy_level;
  logic signed [15:0] out_position;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [15:0]        cfg_data;

  int mismatches;
  int outstanding;
  int results_checked;
  int arrivals;

  int   items_sent = 0;
  int   settings_used = 1;
  int   cur_scale = 7700;
  int   cur_home = 0;
  logic sensor_now = 1'b0;
  bit   calm = 1'b0;
  bit   hold_off_req = 1'b0;
  int   quiet_cycles = 0;

  always #4 clk = ~clk;

  lift_position_slowdown_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_speed_percent   (in_speed_percent),
    .in_target_position (in_target_position),
    .in_sensor_level    (in_sensor_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pwm_output     (out_pwm_output),
    .out_direction_up   (out_direction_up),
    .out_clock_enable   (out_clock_enable),
    .out_high_current   (out_high_current),
    .out_busy_level     (out_busy_level),
    .out_position       (out_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  lift_drive_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_speed_percent   (in_speed_percent),
    .in_target_position (in_target_position),
    .in_sensor_level    (in_sensor_level),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pwm_output     (out_pwm_output),
    .out_direction_up   (out_direction_up),
    .out_clock_enable   (out_clock_enable),
    .out_high_current   (out_high_current),
    .out_busy_level     (out_busy_level),
    .out_position       (out_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .results_checked    (results_checked),
    .arrivals           (arrivals)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_speed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'd0;
    if (r < 8) return 8'd1;
    if (r < 18) return 8'($urandom_range(101, 255));
    return 8'($urandom_range(2, 100));
  endfunction

  function automatic logic signed [15:0] target_for(input int goal);
    longint t;
    if (cur_scale == 0) return 16'($urandom);
    t = (longint'(goal) * 10000) / longint'(cur_scale);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  task automatic send_request(input logic [1:0] act, input logic [7:0] spd,
                              input logic signed [15:0] tgt, input logic lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_speed_percent <= spd;
    in_target_position <= tgt;
    in_sensor_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // One move: start anywhere, reload the position from the sensor count by
  // toggling the sensor level, then start toward an end count close to it
  // and pulse until the motor should have arrived.
  task automatic run_move();
    int   span;
    int   goal;
    int   steps;
    int   r;
    logic lvl;
    lvl = sensor_now;
    send_request(ACT_START, rand_speed(), 16'($urandom), lvl);
    lvl = ~lvl;
    send_request(ACT_PULSE, 8'($urandom), 16'($urandom), lvl);
    r = $urandom_range(0, 99);
    if (r < 10) span = $urandom_range(0, 3);
    else if (r < 85) span = $urandom_range(4, 180);
    else span = $urandom_range(181, 420);
    goal = ($urandom_range(0, 1) == 1) ? cur_home + span : cur_home - span;
    send_request(ACT_START, rand_speed(), target_for(goal), lvl);
    steps = span + $urandom_range(0, 4);
    repeat (steps) begin
      r = $urandom_range(0, 199);
      if (r == 0) begin
        send_request(ACT_STOP, 8'($urandom), 16'($urandom), lvl);
      end else if (r < 3) begin
        lvl = ~lvl;
        send_request(ACT_PULSE, 8'($urandom), 16'($urandom), lvl);
      end else if (r < 6) begin
        send_request(2'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        send_request(ACT_PULSE, 8'($urandom), 16'($urandom), lvl);
      end
    end
    if ($urandom_range(0, 1) == 1)
      send_request(ACT_STOP, 8'($urandom), 16'($urandom), lvl);
    sensor_now = lvl;
  endtask

  task automatic run_phase(input bit write_regs, input logic [15:0] scale_word,
                           input logic signed [15:0] home_word);
    int stop_at;
    if (write_regs) begin
      settle();
      write_register(CFG_COUNTS_PER_UNIT, scale_word);
      write_register(CFG_SENSOR_COUNT, home_word);
      cfg_valid <= 1'b0;
      cur_scale = int'(scale_word[14:0]);
      cur_home = int'(home_word);
      settings_used++;
    end
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at && items_sent < ITEM_TARGET) run_move();
  endtask

  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_START;
    in_speed_percent <= 8'd0;
    in_target_position <= 16'sd0;
    in_sensor_level <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_COUNTS_PER_UNIT;
    cfg_data <= 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings.
    send_request(ACT_PULSE, 8'd0, 16'sd0, 1'b1);
    send_request(ACT_START, 8'd0, 16'sd32767, 1'b1);
    send_request(ACT_UNUSED, 8'd255, -16'sd1, 1'b1);
    send_request(ACT_START, 8'd1, 16'sd0, 1'b0);
    send_request(ACT_START, 8'd255, 16'sd32767, 1'b1);
    send_request(ACT_PULSE, 8'd255, -16'sd1, 1'b1);
    send_request(ACT_PULSE, 8'd0, 16'sd0, 1'b0);
    send_request(ACT_START, 8'd2, 16'sd0, 1'b0);
    send_request(ACT_PULSE, 8'd0, 16'sd0, 1'b0);
    send_request(ACT_PULSE, 8'd0, 16'sd0, 1'b0);
    send_request(ACT_START, 8'd100, -16'sd32768, 1'b0);
    send_request(ACT_PULSE, 8'd0, 16'sd0, 1'b0);
    send_request(ACT_PULSE, 8'd0, 16'sd0, 1'b0);
    send_request(ACT_START, 8'd150, -16'sd3, 1'b0);
    send_request(ACT_PULSE, 8'd0, 16'sd0, 1'b0);
    send_request(ACT_STOP, 8'd0, 16'sd0, 1'b0);
    send_request(ACT_START, 8'd99, 16'sd1, 1'b1);
    send_request(ACT_PULSE, 8'd170, 16'sd21845, 1'b1);
    send_request(ACT_STOP, 8'd85, -16'sd21846, 1'b1);
    send_request(ACT_UNUSED, 8'd0, 16'sd0, 1'b0);
    sensor_now = 1'b0;

    // The long hold-off falls in a phase without register writes, so the
    // sender keeps offering requests while the results are held back.
    hold_off_req = 1'b1;
    run_phase(1'b0, 16'd0, 16'sd0);
    run_phase(1'b1, 16'd0, 16'sd100);
    run_phase(1'b1, 16'd10000, 16'sd1000);
    run_phase(1'b1, 16'h8001, -16'sd32768);
    calm = 1'b1;
    run_phase(1'b1, 16'd32767, 16'sd32767);
    calm = 1'b0;
    run_phase(1'b1, 16'($urandom_range(1, 32767)), 16'($urandom_range(0, 2000) - 1000));
    run_phase(1'b1, 16'd10000, -16'sd200);
    while (items_sent < ITEM_TARGET) run_move();

    settle();
    $display("Sent %0d requests over %0d register settings; %0d results checked.",
             items_sent, settings_used, results_checked);
    $display("%0d moves reached their end count; %0d mismatches.", arrivals, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
